/* sv/zba_pkg.sv */
// Shared types and constants of the zone bitmap allocator.
`default_nettype none
package zba_pkg;

    // Field widths of the request and result items.
    localparam int KIND_W     = 3;
    localparam int ZONE_W     = 16;
    localparam int IDX_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CURSOR_W   = 11;
    localparam int BIT_W      = 3;
    localparam int EXT_W      = 14;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Largest scan limit that the map size register can express.
    localparam int MAP_CAP_MAX = 2047;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BYTES  = 2'd2;

    // Outcome of searching one bitmap byte for a clear bit.
    typedef struct packed {
        logic              hit;
        logic [BIT_W-1:0]  bit_idx;
        logic [BYTE_W-1:0] byte_out;
    } pick_t;

endpackage
`default_nettype wire

/* sv/zone_bitmap_allocator_core.sv */
// Top level of the zone bitmap allocator with its bitmap memory and sequencer.
`default_nettype none
// Usage:
// Requests enter on the s_ channel; the request kind travels in s_tuser and the
// zone, byte index and byte value in s_tdata. Every request gives exactly one
// result item on the m_ channel. Configuration registers are written through
// cfg_we / cfg_index / cfg_data and must only change while no item is in flight.
// The bitmap lives in a single-port-write, registered-read memory of MAP_BYTES
// bytes. Software loads every byte before it is used; it is not cleared at reset.
// Sequence: a load, restart or rejected request goes from the execute state to
// the done state; a free or read passes a write-back state on the way; an
// allocate passes the scan state, which examines one bitmap byte per cycle
// through the memory read port. One item is processed at a time, and the next
// item is accepted in the cycle after the result is handed to the output register.
// Reset clears the cursor, the end and changed flags and the output valid flag, and
// restores the configuration registers to their defaults.
// If the receiver stalls, the result waits in the output register; the block can
// accept and work on one more item, and holds its result until the register frees.
module zone_bitmap_allocator_core #(
    parameter int MAP_BYTES = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: zone_number[15:0], byte_index[25:16], byte_value[33:26].
    input  wire logic [zba_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0: kind[2:0].
    input  wire logic [zba_pkg::KIND_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // Fields from bit 0: allocated_zone[15:0], status[17:16], read_byte[25:18],
    // map_changed[26], at_end[27].
    output logic [zba_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [zba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [zba_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int EW     = zba_pkg::EXT_W;
    localparam int CW     = zba_pkg::CURSOR_W;
    localparam int MapCap = (MAP_BYTES > zba_pkg::MAP_CAP_MAX) ? zba_pkg::MAP_CAP_MAX
                                                              : MAP_BYTES;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_FREE_WB = 3'd3;
    localparam logic [2:0] ST_READ_WB = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // Control state.
    logic [2:0]                      state_reg, state_next;
    logic [CW-1:0]                   cursor_byte_reg, cursor_byte_next;
    logic [zba_pkg::BIT_W-1:0]       cursor_bit_reg, cursor_bit_next;
    logic                            end_reg, end_next;
    logic                            changed_reg, changed_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // Configuration registers.
    logic [zba_pkg::ZONE_W-1:0]      first_zone_reg;
    logic                            write_en_reg;
    logic [CW-1:0]                   map_bytes_reg;

    // Captured request and pending result.
    logic [zba_pkg::KIND_W-1:0]      req_kind_reg;
    logic [zba_pkg::ZONE_W-1:0]      req_zone_reg;
    logic [zba_pkg::IDX_W-1:0]       req_idx_reg;
    logic [zba_pkg::BYTE_W-1:0]      req_val_reg;
    logic [zba_pkg::ZONE_W-1:0]      res_zone_reg, res_zone_next;
    logic [zba_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [zba_pkg::BYTE_W-1:0]      res_rd_reg, res_rd_next;
    logic [zba_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // Bitmap memory and its ports.
    logic [zba_pkg::BYTE_W-1:0]      mem [MAP_BYTES];
    logic                            mem_we;
    logic                            mem_re;
    logic [AW-1:0]                   mem_waddr;
    logic [AW-1:0]                   mem_raddr;
    logic [zba_pkg::BYTE_W-1:0]      mem_wdata;
    logic [zba_pkg::BYTE_W-1:0]      mem_rdata_reg;

    // Derived values.
    logic [CW-1:0]                   limit;
    logic [CW-1:0]                   cursor_inc;
    logic [EW-1:0]                   cursor_ext;
    logic [EW-1:0]                   inc_ext;
    logic [EW-1:0]                   idx_ext;
    logic [EW-1:0]                   free_ext;
    logic [17:0]                     rel_sum;
    logic                            free_oor;
    logic                            idx_ok;
    logic [zba_pkg::BIT_W-1:0]       free_bit;
    logic [zba_pkg::ZONE_W-1:0]      zone_sum;
    logic                            out_free;
    zba_pkg::pick_t                  pick;

    // The scan never goes past the memory, nor past the size register.
    assign limit = (map_bytes_reg < CW'(MapCap)) ? map_bytes_reg : CW'(MapCap);

    assign cursor_inc = cursor_byte_reg + CW'(1);
    assign cursor_ext = EW'(cursor_byte_reg);
    assign inc_ext    = EW'(cursor_inc);
    assign idx_ext    = EW'(req_idx_reg);
    assign idx_ok     = idx_ext < EW'(MAP_BYTES);

    // A free maps the zone back to a bit position relative to the first data zone.
    // Bit 17 of the sum flags a zone below the start of the map.
    assign rel_sum  = 18'(req_zone_reg) + 18'd1 - 18'(first_zone_reg);
    assign free_oor = rel_sum[17] || (rel_sum[16:0] >= {3'b000, limit, 3'b000});
    assign free_ext = EW'(rel_sum[13:3]);
    assign free_bit = rel_sum[2:0];

    // Zone number of the bit found by the scan, wrapping modulo 2^16.
    assign zone_sum = 16'({cursor_byte_reg, pick.bit_idx}) + first_zone_reg + 16'hffff;

    assign out_free = !m_tvalid_reg || m_tready;

    zba_bit_pick u_pick (
        .data  (mem_rdata_reg),
        .start (cursor_bit_reg),
        .pick  (pick)
    );

    // Sequencer: every memory access is finished before the next item is taken,
    // so a read never meets a pending write to the same byte.
    always_comb
    begin
        state_next       = state_reg;
        cursor_byte_next = cursor_byte_reg;
        cursor_bit_next  = cursor_bit_reg;
        end_next         = end_reg;
        changed_next     = changed_reg;
        res_zone_next    = res_zone_reg;
        res_status_next  = res_status_reg;
        res_rd_next      = res_rd_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = '0;
        mem_raddr        = '0;
        mem_wdata        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_zone_next   = '0;
                res_status_next = zba_pkg::STATUS_OK;
                res_rd_next     = '0;
                state_next      = ST_DONE;
                case (req_kind_reg)
                    zba_pkg::KIND_ALLOC:
                    begin
                        if (!write_en_reg || (cursor_byte_reg >= limit))
                        begin
                            end_next        = 1'b1;
                            res_status_next = zba_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cursor_ext[AW-1:0];
                            state_next = ST_SCAN;
                        end
                    end
                    zba_pkg::KIND_FREE:
                    begin
                        if (free_oor)
                        begin
                            res_status_next = zba_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = free_ext[AW-1:0];
                            state_next = ST_FREE_WB;
                        end
                    end
                    zba_pkg::KIND_LOAD:
                    begin
                        if (idx_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_ext[AW-1:0];
                            mem_wdata = req_val_reg;
                        end
                        changed_next = 1'b0;
                    end
                    zba_pkg::KIND_READ:
                    begin
                        if (idx_ok)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = idx_ext[AW-1:0];
                            state_next = ST_READ_WB;
                        end
                    end
                    zba_pkg::KIND_RESTART:
                    begin
                        cursor_byte_next = '0;
                        cursor_bit_next  = '0;
                        end_next         = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (pick.hit)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = cursor_ext[AW-1:0];
                    mem_wdata       = pick.byte_out;
                    changed_next    = 1'b1;
                    cursor_bit_next = pick.bit_idx;
                    res_zone_next   = zone_sum;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cursor_byte_next = cursor_inc;
                    cursor_bit_next  = '0;
                    if (cursor_inc >= limit)
                    begin
                        end_next        = 1'b1;
                        res_status_next = zba_pkg::STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = inc_ext[AW-1:0];
                    end
                end
            end
            ST_FREE_WB:
            begin
                mem_we       = 1'b1;
                mem_waddr    = free_ext[AW-1:0];
                mem_wdata    = mem_rdata_reg & ~(8'd1 << free_bit);
                changed_next = 1'b1;
                state_next   = ST_DONE;
            end
            ST_READ_WB:
            begin
                res_rd_next = mem_rdata_reg;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cursor_byte_reg <= '0;
            cursor_bit_reg  <= '0;
            end_reg         <= 1'b0;
            changed_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_byte_reg <= cursor_byte_next;
            cursor_bit_reg  <= cursor_bit_next;
            end_reg         <= end_next;
            changed_reg     <= changed_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Configuration registers; an index past the list writes nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_zone_reg <= 16'd1;
            write_en_reg   <= 1'b1;
            map_bytes_reg  <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zba_pkg::CFG_FIRST_ZONE: first_zone_reg <= cfg_data;
                zba_pkg::CFG_WRITE_EN:   write_en_reg   <= cfg_data[0];
                zba_pkg::CFG_MAP_BYTES:  map_bytes_reg  <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_kind_reg <= s_tuser;
            req_zone_reg <= s_tdata[15:0];
            req_idx_reg  <= s_tdata[25:16];
            req_val_reg  <= s_tdata[33:26];
        end
        res_zone_reg   <= res_zone_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {4'b0000, end_reg, changed_reg, res_rd_reg,
                            res_status_reg, res_zone_reg};
        end
    end

    // Bitmap memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The memory is only written while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_EXEC) || (state_reg == ST_SCAN) ||
                    (state_reg == ST_FREE_WB)))
        else $error("bitmap written outside of an active request");

    // A result enters the output register only as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> (state_reg == ST_IDLE))
        else $error("result presented without finishing a request");

    // The scan only reads bytes that lie below the scan limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cursor_byte_reg < limit))
        else $error("scan cursor past the scan limit");

    // A successful allocate marks the map as changed and ends the request.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && pick.hit) |=> (changed_reg && (state_reg == ST_DONE)))
        else $error("allocate hit did not update changed flag");

    // The block stays busy while a finished result cannot be handed over.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while the receiver stalled");

endmodule
`default_nettype wire

/* sv/zba_bit_pick.sv */
// Finds the lowest clear bit of a bitmap byte at or above a start bit.
`default_nettype none
module zba_bit_pick (
    input  wire logic [zba_pkg::BYTE_W-1:0] data,
    input  wire logic [zba_pkg::BIT_W-1:0]  start,
    output zba_pkg::pick_t                  pick
);

    logic [zba_pkg::BYTE_W-1:0] masked;
    logic                       hit;
    logic [zba_pkg::BIT_W-1:0]  idx;

    // Bits below the start position count as taken.
    always_comb
    begin
        masked = data | ((8'd1 << start) - 8'd1);
        hit    = 1'b0;
        idx    = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                hit = 1'b1;
                idx = 3'(i);
            end
        end
    end

    assign pick.hit      = hit;
    assign pick.bit_idx  = idx;
    assign pick.byte_out = data | (8'd1 << idx);

endmodule
`default_nettype wire

/* verif/tb_zone_bitmap_allocator_core.sv */
// Self-checking testbench of the zone bitmap allocator core, with a predictor of its own.
`timescale 1ns / 1ps
module tb_zone_bitmap_allocator_core;
    import zba_pkg::*;

    // Bitmap depth of the instance and the run bounds.
    localparam int MAP_DEPTH    = 1024;
    localparam int RANDOM_ITEMS = 300;
    localparam int MAX_GAP      = 19;
    localparam int END_WAIT     = 40;
    // Worst case per item: sender gap, a scan over the whole map and a receiver
    // stall, over all items (fill, table and random part), taken three times.
    localparam int CYCLE_LIMIT  = 5_000_000;

    // Highest first data zone at which the last zone of a full-size map still fits in 16 bits.
    localparam logic [CFG_DATA_W-1:0] FIRST_ZONE_MAX = 16'd57345;

    // Request kinds that the block does not use.
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    // One result item as it sits in the low bits of m_tdata.
    typedef struct packed {
        logic                at_end;
        logic                map_changed;
        logic [BYTE_W-1:0]   read_byte;
        logic [STATUS_W-1:0] status;
        logic [ZONE_W-1:0]   zone;
    } zone_result_t;

    // One row of the directed plan: either a register write or a request.
    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        logic [KIND_W-1:0]     kind;
        logic [ZONE_W-1:0]     zone;
        logic [IDX_W-1:0]      idx;
        logic [BYTE_W-1:0]     val;
        bit                    typed;
        zone_result_t          want;
    } plan_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow of the block: bitmap, next-fit cursor, flags and registers.
    logic [BYTE_W-1:0]     map_model [MAP_DEPTH];
    int                    scan_byte;
    int                    scan_bit;
    bit                    end_model;
    bit                    changed_model;
    logic [CFG_DATA_W-1:0] first_zone_reg;
    bit                    alloc_enable_reg;
    logic [CURSOR_W-1:0]   map_bytes_reg;

    // Results still owed by the block, oldest first.
    zone_result_t expected_results[$];
    plan_row_t    directed_plan[$];

    int          mismatches  = 0;
    int unsigned cycle_count = 0;
    int          stall_left  = 0;
    // When clear, both sides run back to back with no gaps or stalls.
    bit          idle_gaps   = 1'b0;

    zone_bitmap_allocator_core #(
        .MAP_BYTES(MAP_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    // Works out the result of one request and advances the shadow state.
    function automatic zone_result_t predict_zone_result(
        input logic [KIND_W-1:0] kind,
        input logic [ZONE_W-1:0] zone_in,
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] val
    );
        zone_result_t r;
        int           lim;
        int           rel;
        bit           found;
        r     = '0;
        found = 1'b0;
        lim   = (map_bytes_reg < MAP_DEPTH) ? int'(map_bytes_reg) : MAP_DEPTH;
        case (kind)
            KIND_ALLOC:
            begin
                if (alloc_enable_reg)
                begin
                    // Resume at the cursor; full bytes are skipped whole, and
                    // the cursor stays on the bit that it hands out.
                    while (!found && scan_byte < lim)
                    begin
                        if (map_model[scan_byte] != 8'hff)
                        begin
                            while (!found && scan_bit < 8)
                            begin
                                if (!map_model[scan_byte][scan_bit])
                                begin
                                    found = 1'b1;
                                    map_model[scan_byte][scan_bit] = 1'b1;
                                    changed_model = 1'b1;
                                    r.zone = 16'(scan_byte * 8 + scan_bit
                                                 + int'(first_zone_reg) + 65535);
                                end
                                else
                                begin
                                    scan_bit++;
                                end
                            end
                        end
                        if (!found)
                        begin
                            scan_byte++;
                            scan_bit = 0;
                        end
                    end
                end
                // Disabled, exhausted, or cursor already past the limit.
                if (!found)
                begin
                    end_model = 1'b1;
                    r.status  = STATUS_FULL;
                end
            end
            KIND_FREE:
            begin
                rel = int'(zone_in) + 1 - int'(first_zone_reg);
                if (rel < 0 || rel >= lim * 8)
                begin
                    r.status = STATUS_RANGE;
                end
                else
                begin
                    map_model[rel >> 3][rel & 7] = 1'b0;
                    changed_model = 1'b1;
                end
            end
            KIND_LOAD:
            begin
                map_model[idx] = val;
                changed_model  = 1'b0;
            end
            KIND_READ:
            begin
                r.read_byte = map_model[idx];
            end
            KIND_RESTART:
            begin
                scan_byte = 0;
                scan_bit  = 0;
                end_model = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.map_changed = changed_model;
        r.at_end      = end_model;
        return r;
    endfunction

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] i,
                                     input logic [CFG_DATA_W-1:0] v);
        plan_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = i;
        r.cfg_val = v;
        directed_plan.push_back(r);
    endfunction

    function automatic void plan_item(input logic [KIND_W-1:0] k, input logic [ZONE_W-1:0] z,
                                      input logic [IDX_W-1:0] i, input logic [BYTE_W-1:0] v);
        plan_row_t r;
        r      = '0;
        r.kind = k;
        r.zone = z;
        r.idx  = i;
        r.val  = v;
        directed_plan.push_back(r);
    endfunction

    // A request whose result is plain to see; the allocated zone is always 0 here.
    function automatic void plan_checked(input logic [KIND_W-1:0] k, input logic [ZONE_W-1:0] z,
                                         input logic [IDX_W-1:0] i, input logic [BYTE_W-1:0] v,
                                         input logic [STATUS_W-1:0] st,
                                         input logic [BYTE_W-1:0] rd,
                                         input logic ch, input logic en);
        plan_row_t r;
        r       = '0;
        r.kind  = k;
        r.zone  = z;
        r.idx   = i;
        r.val   = v;
        r.typed = 1'b1;
        r.want  = {en, ch, rd, st, 16'd0};
        directed_plan.push_back(r);
    endfunction

    // Register writes happen only with nothing in flight. The enable is
    // dropped before the next write may raise it again.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_FIRST_ZONE: first_zone_reg   = value;
            CFG_WRITE_EN:   alloc_enable_reg = value[0];
            CFG_MAP_BYTES:  map_bytes_reg    = value[CURSOR_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Offers one request, after a random gap if gaps are on, and returns at the edge where it
    // is taken. Valid stays high so a back-to-back item needs no re-raise.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ZONE_W-1:0] zone,
                                input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                                input bit typed, input zone_result_t want);
        int           gap;
        zone_result_t predicted;
        gap = idle_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predicted = predict_zone_result(kind, zone, idx, val);
        expected_results.push_back(typed ? want : predicted);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, val, idx, zone};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Receiver: after each item it stalls for a drawn number of cycles in
    // which a result is waiting; ready may also sit high with nothing offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            stall_left = idle_gaps ? $urandom_range(0, MAX_GAP) : 0;
            m_tready   <= (stall_left == 0);
        end
        else if (!m_tready)
        begin
            if (stall_left == 0)
                m_tready <= 1'b1;
            else if (m_tvalid)
                stall_left--;
        end
    end

    // Result checker: every accepted item is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        zone_result_t seen;
        zone_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = m_tdata[27:0];
            if (expected_results.size() == 0)
            begin
                $error("result item arrived with no request outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.zone !== want.zone)
                begin
                    $error("allocated_zone: expected %0d, actual %0d", want.zone, seen.zone);
                    mismatches++;
                end
                if (seen.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, seen.status);
                    mismatches++;
                end
                if (seen.read_byte !== want.read_byte)
                begin
                    $error("read_byte: expected %h, actual %h", want.read_byte, seen.read_byte);
                    mismatches++;
                end
                if (seen.map_changed !== want.map_changed)
                begin
                    $error("map_changed: expected %0b, actual %0b",
                           want.map_changed, seen.map_changed);
                    mismatches++;
                end
                if (seen.at_end !== want.at_end)
                begin
                    $error("at_end: expected %0b, actual %0b", want.at_end, seen.at_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        plan_row_t           row;
        int                  sent;
        int                  phase_len;
        int                  pick;
        int                  sel;
        int                  lim;
        int                  rel;
        logic [KIND_W-1:0]   k;
        logic [ZONE_W-1:0]   z;
        logic [IDX_W-1:0]    ix;
        logic [BYTE_W-1:0]   v;
        logic [CFG_DATA_W-1:0] fz;

        scan_byte        = 0;
        scan_bit         = 0;
        end_model        = 1'b0;
        changed_model    = 1'b0;
        first_zone_reg   = 16'd1;
        alloc_enable_reg = 1'b1;
        map_bytes_reg    = 11'd1024;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The bitmap holds garbage until software loads it, so every byte is
        // loaded first, back to back. Some bytes come out full, some empty.
        idle_gaps = 1'b0;
        for (int i = 0; i < MAP_DEPTH; i++)
        begin
            case ($urandom_range(0, 7))
                0:       v = 8'hff;
                1:       v = 8'h00;
                default: v = 8'($urandom);
            endcase
            send_request(KIND_LOAD, 16'($urandom), 10'(i), v, 1'b0, '0);
        end

        // Directed plan. After the fill the changed and end flags are both clear.
        // Allocation disabled: fails with the end flag set, and a restart clears it.
        plan_cfg(CFG_WRITE_EN, 16'd0);
        plan_checked(KIND_ALLOC, 16'd0, 10'd0, 8'd0, STATUS_FULL, 8'd0, 1'b0, 1'b1);
        plan_checked(KIND_RESTART, 16'd0, 10'd0, 8'd0, STATUS_OK, 8'd0, 1'b0, 1'b0);
        plan_cfg(CFG_WRITE_EN, 16'd1);
        plan_cfg(CFG_FIRST_ZONE, FIRST_ZONE_MAX);
        plan_cfg(CFG_MAP_BYTES, 16'd1024);
        // Top byte of the map: load, read back, then free its last zone.
        plan_checked(KIND_LOAD, 16'hffff, 10'd1023, 8'h7f, STATUS_OK, 8'd0, 1'b0, 1'b0);
        plan_checked(KIND_READ, 16'd0, 10'd1023, 8'd0, STATUS_OK, 8'h7f, 1'b0, 1'b0);
        plan_item(KIND_FREE, 16'hffff, 10'd0, 8'd0);
        // Frees below the first data zone are rejected and leave the flag alone.
        plan_checked(KIND_FREE, 16'd57343, 10'd0, 8'd0, STATUS_RANGE, 8'd0, 1'b1, 1'b0);
        plan_checked(KIND_FREE, 16'd0, 10'd0, 8'd0, STATUS_RANGE, 8'd0, 1'b1, 1'b0);
        // An empty scan range: nothing to allocate and nothing to free.
        plan_cfg(CFG_MAP_BYTES, 16'd0);
        plan_checked(KIND_ALLOC, 16'd0, 10'd0, 8'd0, STATUS_FULL, 8'd0, 1'b1, 1'b1);
        plan_checked(KIND_FREE, 16'd57344, 10'd0, 8'd0, STATUS_RANGE, 8'd0, 1'b1, 1'b1);
        plan_checked(KIND_RESTART, 16'd0, 10'd0, 8'd0, STATUS_OK, 8'd0, 1'b1, 1'b0);
        // One-byte map with one clear bit: zone 0 comes out as a valid zone,
        // then the map runs dry and stays dry until a restart.
        plan_cfg(CFG_MAP_BYTES, 16'd1);
        plan_cfg(CFG_FIRST_ZONE, 16'd1);
        plan_checked(KIND_LOAD, 16'd0, 10'd0, 8'hfe, STATUS_OK, 8'd0, 1'b0, 1'b0);
        plan_item(KIND_ALLOC, 16'd0, 10'd0, 8'd0);
        plan_item(KIND_ALLOC, 16'd0, 10'd0, 8'd0);
        plan_item(KIND_ALLOC, 16'd0, 10'd0, 8'd0);
        plan_item(KIND_RESTART, 16'd0, 10'd0, 8'd0);
        // Move the cursor to byte 1, then lower the limit below it.
        plan_cfg(CFG_MAP_BYTES, 16'd1024);
        plan_item(KIND_LOAD, 16'd0, 10'd0, 8'hff);
        plan_item(KIND_LOAD, 16'd0, 10'd1, 8'h00);
        plan_item(KIND_ALLOC, 16'd0, 10'd0, 8'd0);
        plan_cfg(CFG_MAP_BYTES, 16'd1);
        plan_item(KIND_ALLOC, 16'd0, 10'd0, 8'd0);
        plan_item(KIND_RESTART, 16'd0, 10'd0, 8'd0);
        // Unused kinds do nothing.
        for (int u = KIND_SPARE_FIRST; u <= KIND_SPARE_LAST; u++)
            plan_item(3'(u), (u[0] ? 16'hffff : 16'd0), (u[0] ? 10'd1023 : 10'd0),
                      (u[0] ? 8'hff : 8'h00));
        // Largest first data zone on a full-size map.
        plan_cfg(CFG_MAP_BYTES, 16'd1024);
        plan_cfg(CFG_FIRST_ZONE, FIRST_ZONE_MAX);
        plan_item(KIND_ALLOC, 16'd0, 10'd0, 8'd0);

        idle_gaps = 1'b1;
        foreach (directed_plan[n])
        begin
            row = directed_plan[n];
            if (row.is_cfg)
            begin
                wait_drained();
                write_register(row.cfg_idx, row.cfg_val);
            end
            else
            begin
                send_request(row.kind, row.zone, row.idx, row.val, row.typed, row.want);
            end
        end

        // Random phases. Each one starts from a drained block with fresh register
        // values; small maps make exhaustion common.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            case ($urandom_range(0, 3))
                0:       fz = 16'd1;
                1:       fz = FIRST_ZONE_MAX;
                default: fz = 16'($urandom_range(1, FIRST_ZONE_MAX));
            endcase
            write_register(CFG_FIRST_ZONE, fz);
            write_register(CFG_WRITE_EN, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'd1);
            case ($urandom_range(0, 4))
                0:       write_register(CFG_MAP_BYTES, 16'd1024);
                1:       write_register(CFG_MAP_BYTES, 16'($urandom_range(0, 8)));
                2:       write_register(CFG_MAP_BYTES, 16'($urandom_range(1020, 1024)));
                default: write_register(CFG_MAP_BYTES, 16'($urandom_range(0, 1024)));
            endcase
            idle_gaps = ($urandom_range(0, 3) != 0);
            lim       = (map_bytes_reg < MAP_DEPTH) ? int'(map_bytes_reg) : MAP_DEPTH;
            phase_len = $urandom_range(40, 120);
            repeat (phase_len)
            begin
                z    = 16'($urandom);
                ix   = 10'($urandom);
                v    = 8'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    k = KIND_ALLOC;
                end
                else if (pick < 60)
                begin
                    // Mostly zones inside the scan range, some just outside
                    // either end, and some anywhere at all.
                    k   = KIND_FREE;
                    sel = $urandom_range(0, 9);
                    if (sel != 2)
                    begin
                        if (sel == 0)
                            rel = -1;
                        else if (sel == 1 || lim == 0)
                            rel = lim * 8;
                        else
                            rel = $urandom_range(0, lim * 8 - 1);
                        z = 16'(int'(first_zone_reg) - 1 + rel);
                    end
                end
                else if (pick < 72)
                begin
                    k = KIND_LOAD;
                    if (lim > 0 && $urandom_range(0, 1) == 0)
                        ix = 10'($urandom_range(0, lim - 1));
                    if ($urandom_range(0, 3) == 0)
                        v = 8'hff;
                end
                else if (pick < 85)
                begin
                    k = KIND_READ;
                    if (lim > 0 && $urandom_range(0, 1) == 0)
                        ix = 10'($urandom_range(0, lim - 1));
                end
                else if (pick < 93)
                begin
                    k = KIND_RESTART;
                end
                else
                begin
                    k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
                end
                send_request(k, z, ix, v, 1'b0, '0);
                if (k <= KIND_RESTART)
                    sent++;
            end
        end

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
